// ===== rtl/core/spose_pkg.sv =====
// ----------------------------------------------------------------------------
// Servo pose interpolator package
// Shared constants, command and register codes, controller types.
// ----------------------------------------------------------------------------
package spose_pkg;

   localparam int MAX_SERVOS_DEF = 32;
   localparam int POSE_SHIFT_DEF = 3;
   localparam int CENTER_POS     = 512;
   localparam int RESULT_LIMIT   = 32;
   localparam int DIV_W          = 16;

   localparam logic [5:0] SERVO_COUNT_RST = 6'd18;
   localparam logic [7:0] FRAME_LEN_RST   = 8'd33;

   localparam logic [1:0] CMD_LOAD_TARGET  = 2'd0;
   localparam logic [1:0] CMD_LOAD_CURRENT = 2'd1;
   localparam logic [1:0] CMD_START        = 2'd2;
   localparam logic [1:0] CMD_TICK         = 2'd3;

   localparam logic [1:0] REG_SERVO_COUNT = 2'd0;
   localparam logic [1:0] REG_FRAME_LEN   = 2'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FRAMES,
      ST_STEP_RD,
      ST_STEP_GO,
      ST_STEP_WAIT,
      ST_TICK_RD,
      ST_TICK_UPD,
      ST_TICK_END,
      ST_EMIT_RD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic idx_clr;
      logic idx_inc;
      logic div_go;
      logic div_sel_gap;
      logic frames_ld;
      logic step_wr;
      logic arm_set;
      logic tick_begin;
      logic pose_upd;
      logic tick_end;
      logic emit;
   } ctl_cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       armed;
      logic       n_zero;
      logic       idx_last;
      logic       div_done;
   } ctl_sts_type;

endpackage

// ===== rtl/core/servo_pose_interpolator.sv =====
// ----------------------------------------------------------------------------
// Servo pose interpolator
// Keyframe linear interpolation of a pose of up to 32 servos.
// ----------------------------------------------------------------------------
// Commands enter on req_* and transfer at a clock edge with start high and
// busy low. Load target and load current write one slot. Start divides
// duration by frame length, then runs one division per servo, all on the
// shared divider. A tick while armed updates every servo, then emits one
// result per servo on rsp_*, marked by rsp_strobe, rsp_last on the final
// one. A tick while disarmed emits nothing. The receiver cannot stall;
// every result stays one cycle on the ports. Registers are written through
// csr_* while busy is low. Reset disarms the block, centres every current
// and target position and restores servo_count 18 and frame_length_ms 33.
// ----------------------------------------------------------------------------
module servo_pose_interpolator #(
   parameter int MAX_SERVOS = spose_pkg::MAX_SERVOS_DEF,
   parameter int POSE_SHIFT = spose_pkg::POSE_SHIFT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [4:0]  req_servo_index,
   input  logic [9:0]  req_position,
   input  logic [15:0] req_duration_ms,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   output logic        rsp_strobe,
   output logic [4:0]  rsp_slot,
   output logic [9:0]  rsp_servo_position,
   output logic        rsp_still_moving,
   output logic        rsp_last
);

   spose_pkg::ctl_cmd_type ctl_cmd;
   spose_pkg::ctl_sts_type ctl_sts;

   assign csr_ready = ~busy;

   spose_ctl u_ctl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (ctl_sts),
      .busy  (busy),
      .cmd   (ctl_cmd)
   );

   spose_dp #(.MAX_SERVOS(MAX_SERVOS), .POSE_SHIFT(POSE_SHIFT)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (ctl_cmd),
      .sts                (ctl_sts),
      .req_command        (req_command),
      .req_servo_index    (req_servo_index),
      .req_position       (req_position),
      .req_duration_ms    (req_duration_ms),
      .csr_we             (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_strobe         (rsp_strobe),
      .rsp_slot           (rsp_slot),
      .rsp_servo_position (rsp_servo_position),
      .rsp_still_moving   (rsp_still_moving),
      .rsp_last           (rsp_last)
   );

`ifndef ASSERT_OFF
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not raise busy");

   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("results on consecutive cycles");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |-> ##2 rsp_strobe)
      else $error("result run broken before last");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |-> !busy)
      else $error("busy after final result");
`endif

endmodule

// ===== rtl/core/spose_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spose_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                            wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                            rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/spose_div.sv =====
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spose_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         go,
   input  logic [spose_pkg::DIV_W-1:0]  dividend,
   input  logic [spose_pkg::DIV_W-1:0]  divisor,
   output logic                         done,
   output logic [spose_pkg::DIV_W-1:0]  quotient
);

   localparam int W  = spose_pkg::DIV_W;
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  rem_ff;
   logic [W-1:0]  quo_ff;
   logic [W-1:0]  dsr_ff;
   logic [CW-1:0] cnt_ff;
   logic          run_ff;
   logic          done_ff;
   logic [W:0]    shifted;
   logic [W:0]    trial;
   logic          fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[W-1]};
      trial   = shifted - {1'b0, dsr_ff};
      fits    = shifted >= {1'b0, dsr_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            run_ff <= 1'b1;
            cnt_ff <= CW'(W);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dsr_ff <= divisor;
      end else if (run_ff) begin
         rem_ff <= fits ? trial[W-1:0] : shifted[W-1:0];
         quo_ff <= {quo_ff[W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/spose_ctl.sv =====
// ----------------------------------------------------------------------------
// Servo pose interpolator controller
// Sequences load, start and tick commands over the datapath.
// ----------------------------------------------------------------------------
module spose_ctl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  spose_pkg::ctl_sts_type sts,
   output logic                   busy,
   output spose_pkg::ctl_cmd_type cmd
);

   spose_pkg::state_type state_ff;
   spose_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spose_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = state_ff != spose_pkg::ST_IDLE;
      case (state_ff)
         spose_pkg::ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = spose_pkg::ST_DECODE;
            end
         end
         spose_pkg::ST_DECODE: begin
            case (sts.cmd)
               spose_pkg::CMD_START: begin
                  cmd.div_go = 1'b1;
                  state_in   = spose_pkg::ST_FRAMES;
               end
               spose_pkg::CMD_TICK: begin
                  if (sts.armed) begin
                     cmd.tick_begin = 1'b1;
                     cmd.idx_clr    = 1'b1;
                     state_in = sts.n_zero ? spose_pkg::ST_TICK_END : spose_pkg::ST_TICK_RD;
                  end else begin
                     state_in = spose_pkg::ST_IDLE;
                  end
               end
               default: begin
                  state_in = spose_pkg::ST_IDLE;
               end
            endcase
         end
         spose_pkg::ST_FRAMES: begin
            if (sts.div_done) begin
               cmd.frames_ld = 1'b1;
               cmd.idx_clr   = 1'b1;
               if (sts.n_zero) begin
                  cmd.arm_set = 1'b1;
                  state_in    = spose_pkg::ST_IDLE;
               end else begin
                  state_in = spose_pkg::ST_STEP_RD;
               end
            end
         end
         spose_pkg::ST_STEP_RD: begin
            state_in = spose_pkg::ST_STEP_GO;
         end
         spose_pkg::ST_STEP_GO: begin
            cmd.div_go      = 1'b1;
            cmd.div_sel_gap = 1'b1;
            state_in        = spose_pkg::ST_STEP_WAIT;
         end
         spose_pkg::ST_STEP_WAIT: begin
            if (sts.div_done) begin
               cmd.step_wr = 1'b1;
               if (sts.idx_last) begin
                  cmd.arm_set = 1'b1;
                  state_in    = spose_pkg::ST_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = spose_pkg::ST_STEP_RD;
               end
            end
         end
         spose_pkg::ST_TICK_RD: begin
            state_in = spose_pkg::ST_TICK_UPD;
         end
         spose_pkg::ST_TICK_UPD: begin
            cmd.pose_upd = 1'b1;
            if (sts.idx_last) begin
               state_in = spose_pkg::ST_TICK_END;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = spose_pkg::ST_TICK_RD;
            end
         end
         spose_pkg::ST_TICK_END: begin
            cmd.tick_end = 1'b1;
            cmd.idx_clr  = 1'b1;
            state_in = sts.n_zero ? spose_pkg::ST_IDLE : spose_pkg::ST_EMIT_RD;
         end
         spose_pkg::ST_EMIT_RD: begin
            state_in = spose_pkg::ST_EMIT;
         end
         spose_pkg::ST_EMIT: begin
            cmd.emit = 1'b1;
            if (sts.idx_last) begin
               state_in = spose_pkg::ST_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = spose_pkg::ST_EMIT_RD;
            end
         end
         default: begin
            state_in = spose_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/spose_dp.sv =====
// ----------------------------------------------------------------------------
// Servo pose interpolator datapath
// Pose and step memories, divider, frame counters and result registers.
// ----------------------------------------------------------------------------
module spose_dp #(
   parameter int MAX_SERVOS = spose_pkg::MAX_SERVOS_DEF,
   parameter int POSE_SHIFT = spose_pkg::POSE_SHIFT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  spose_pkg::ctl_cmd_type cmd,
   output spose_pkg::ctl_sts_type sts,
   input  logic [1:0]             req_command,
   input  logic [4:0]             req_servo_index,
   input  logic [9:0]             req_position,
   input  logic [15:0]            req_duration_ms,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [7:0]             csr_wdata,
   output logic                   rsp_strobe,
   output logic [4:0]             rsp_slot,
   output logic [9:0]             rsp_servo_position,
   output logic                   rsp_still_moving,
   output logic                   rsp_last
);

   localparam int PB = 10 + POSE_SHIFT;
   localparam int SW = PB + 1;
   localparam int IW = (MAX_SERVOS > 1) ? $clog2(MAX_SERVOS) : 1;
   localparam int DW = spose_pkg::DIV_W;
   localparam logic [PB-1:0] RESET_POSE = PB'(spose_pkg::CENTER_POS << POSE_SHIFT);

   logic [1:0]            cmd_ff;
   logic [15:0]           dur_ff;
   logic [5:0]            servo_count_ff;
   logic [7:0]            frame_len_ff;
   logic [15:0]           frames_planned_ff;
   logic [15:0]           frames_done_ff;
   logic                  armed_ff;
   logic                  all_arr_ff;
   logic [IW-1:0]         idx_ff;
   logic [MAX_SERVOS-1:0] cur_valid_ff;
   logic [MAX_SERVOS-1:0] tgt_valid_ff;
   logic                  cur_vq_ff;
   logic                  tgt_vq_ff;
   logic                  rsp_strobe_ff;
   logic [4:0]            rsp_slot_ff;
   logic [9:0]            rsp_pos_ff;
   logic                  rsp_still_ff;
   logic                  rsp_last_ff;

   logic [6:0]    active_n;
   logic          idx_last;
   logic          load_hit;
   logic          load_tgt;
   logic          load_cur;
   logic [PB-1:0] fine;
   logic [PB-1:0] cur_rd;
   logic [PB-1:0] tgt_rd;
   logic [SW-1:0] step_rd;
   logic [PB-1:0] cur_eff;
   logic [PB-1:0] tgt_eff;
   logic [PB-1:0] gap;
   logic          move_up;
   logic          arrived_now;
   logic [PB-1:0] new_pose;
   logic [7:0]    len_eff;
   logic [DW-1:0] div_dividend;
   logic [DW-1:0] div_divisor;
   logic          div_done;
   logic [DW-1:0] div_q;
   logic [SW-1:0] step_new;
   logic          disarm;
   logic          cur_we;
   logic [IW-1:0] cur_waddr;
   logic [PB-1:0] cur_wdata;

   always_comb begin
      active_n = 7'(servo_count_ff);
      if (active_n > 7'(MAX_SERVOS)) begin
         active_n = 7'(MAX_SERVOS);
      end
      if (active_n > 7'(spose_pkg::RESULT_LIMIT)) begin
         active_n = 7'(spose_pkg::RESULT_LIMIT);
      end
      idx_last = 7'(idx_ff) == (active_n - 7'd1);

      load_hit = cmd.accept && (7'(req_servo_index) < 7'(MAX_SERVOS));
      load_tgt = load_hit && (req_command == spose_pkg::CMD_LOAD_TARGET);
      load_cur = load_hit && (req_command == spose_pkg::CMD_LOAD_CURRENT);
      fine     = PB'(req_position) << POSE_SHIFT;

      cur_eff = cur_vq_ff ? cur_rd : RESET_POSE;
      tgt_eff = tgt_vq_ff ? tgt_rd : RESET_POSE;
      move_up = tgt_eff > cur_eff;
      gap     = move_up ? (tgt_eff - cur_eff) : (cur_eff - tgt_eff);
      arrived_now = (gap == '0) || (SW'(gap) < step_rd);
      if (arrived_now) begin
         new_pose = tgt_eff;
      end else if (move_up) begin
         new_pose = cur_eff + PB'(step_rd);
      end else begin
         new_pose = cur_eff - PB'(step_rd);
      end

      len_eff      = (frame_len_ff == 8'd0) ? 8'd1 : frame_len_ff;
      div_dividend = cmd.div_sel_gap ? DW'(gap) : dur_ff;
      div_divisor  = cmd.div_sel_gap ? frames_planned_ff : DW'(len_eff);
      step_new     = SW'(div_q) + SW'(1);
      disarm       = all_arr_ff && (frames_done_ff >= frames_planned_ff);

      cur_we    = load_cur || cmd.pose_upd;
      cur_waddr = load_cur ? IW'(req_servo_index) : idx_ff;
      cur_wdata = load_cur ? fine : new_pose;
   end

   spose_ram #(.WIDTH(PB), .DEPTH(MAX_SERVOS)) u_cur_ram (
      .clock (clock),
      .we    (cur_we),
      .waddr (cur_waddr),
      .wdata (cur_wdata),
      .raddr (idx_ff),
      .rdata (cur_rd)
   );

   spose_ram #(.WIDTH(PB), .DEPTH(MAX_SERVOS)) u_tgt_ram (
      .clock (clock),
      .we    (load_tgt),
      .waddr (IW'(req_servo_index)),
      .wdata (fine),
      .raddr (idx_ff),
      .rdata (tgt_rd)
   );

   spose_ram #(.WIDTH(SW), .DEPTH(MAX_SERVOS)) u_step_ram (
      .clock (clock),
      .we    (cmd.step_wr),
      .waddr (idx_ff),
      .wdata (step_new),
      .raddr (idx_ff),
      .rdata (step_rd)
   );

   spose_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (cmd.div_go),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         servo_count_ff    <= spose_pkg::SERVO_COUNT_RST;
         frame_len_ff      <= spose_pkg::FRAME_LEN_RST;
         frames_planned_ff <= '0;
         frames_done_ff    <= '0;
         armed_ff          <= 1'b0;
         cur_valid_ff      <= '0;
         tgt_valid_ff      <= '0;
         rsp_strobe_ff     <= 1'b0;
      end else begin
         if (csr_we && (csr_index == spose_pkg::REG_SERVO_COUNT)) begin
            servo_count_ff <= csr_wdata[5:0];
         end
         if (csr_we && (csr_index == spose_pkg::REG_FRAME_LEN)) begin
            frame_len_ff <= csr_wdata;
         end
         if (cmd.frames_ld) begin
            frames_planned_ff <= (div_q == 16'hFFFF) ? 16'hFFFF : div_q + 16'd1;
         end
         if (cmd.tick_begin && (frames_done_ff != 16'hFFFF)) begin
            frames_done_ff <= frames_done_ff + 16'd1;
         end else if (cmd.tick_end && disarm) begin
            frames_done_ff <= '0;
         end
         if (cmd.arm_set) begin
            armed_ff <= 1'b1;
         end else if (cmd.tick_end && disarm) begin
            armed_ff <= 1'b0;
         end
         if (load_cur) begin
            cur_valid_ff[IW'(req_servo_index)] <= 1'b1;
         end else if (cmd.pose_upd) begin
            cur_valid_ff[idx_ff] <= 1'b1;
         end
         if (load_tgt) begin
            tgt_valid_ff[IW'(req_servo_index)] <= 1'b1;
         end
         rsp_strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      cur_vq_ff <= cur_valid_ff[idx_ff];
      tgt_vq_ff <= tgt_valid_ff[idx_ff];
      if (cmd.accept) begin
         cmd_ff <= req_command;
         dur_ff <= req_duration_ms;
      end
      if (cmd.idx_clr) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + IW'(1);
      end
      if (cmd.tick_begin) begin
         all_arr_ff <= 1'b1;
      end else if (cmd.pose_upd) begin
         all_arr_ff <= all_arr_ff && arrived_now;
      end
      if (cmd.emit) begin
         rsp_slot_ff  <= 5'(idx_ff);
         rsp_pos_ff   <= cur_eff[PB-1:POSE_SHIFT];
         rsp_still_ff <= armed_ff;
         rsp_last_ff  <= idx_last;
      end
   end

   always_comb begin
      sts.cmd      = cmd_ff;
      sts.armed    = armed_ff;
      sts.n_zero   = active_n == 7'd0;
      sts.idx_last = idx_last;
      sts.div_done = div_done;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_servo_position = rsp_pos_ff;
   assign rsp_still_moving   = rsp_still_ff;
   assign rsp_last           = rsp_last_ff;

endmodule
